// ----- sv/trigram_indexed_word_lookup_macros.svh -----
// Assertion macros for the trigram indexed word lookup block.
`ifndef TRIGRAM_INDEXED_WORD_LOOKUP_MACROS_SVH
`define TRIGRAM_INDEXED_WORD_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
`define TIWL_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define TIWL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define TIWL_ASSERT_SAME(label, clk, rst, pre, post)
`define TIWL_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ----- sv/tiwl_pkg.sv -----
// Shared constants and types for the trigram indexed word lookup block.
package tiwl_pkg;
   localparam int MAX_LETTERS = 16;
   localparam int WORD_SLOTS = 4096;
   localparam int ALPHABET = 26;
   localparam int GROUP_LETTERS = 3;
   localparam int GROUPS = ALPHABET * ALPHABET * ALPHABET;
   localparam int CODE_W = 5;
   localparam int LEN_W = 5;
   localparam int IDX_W = $clog2(MAX_LETTERS);
   localparam int SLOT_W = $clog2(WORD_SLOTS);
   localparam int TOTAL_W = SLOT_W + 1;
   localparam int ADDR_W = SLOT_W + IDX_W;
   localparam int GROUP_W = $clog2(GROUPS);

   localparam logic [2:0] ST_NOT_FOUND = 3'd0;
   localparam logic [2:0] ST_PREFIX = 3'd1;
   localparam logic [2:0] ST_EXACT = 3'd2;
   localparam logic [2:0] ST_STORED = 3'd3;
   localparam logic [2:0] ST_SHORT = 3'd4;
   localparam logic [2:0] ST_LONG = 3'd5;
   localparam logic [2:0] ST_FULL = 3'd6;
   localparam logic [2:0] ST_ORDER = 3'd7;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_GRPW, S_NEXT, S_CMP, S_COMMIT, S_DONE
   } state_type;

   typedef logic [MAX_LETTERS-1:0][CODE_W-1:0] letters_type;

   typedef struct packed {
      logic done;
      logic func;
      logic [LEN_W-1:0] len;
      logic we;
      logic [ADDR_W-1:0] waddr;
      logic [CODE_W-1:0] wdata;
   } ingest_type;
endpackage

// ----- sv/tiwl_ingest.sv -----
// Letter intake: pending length, word buffer and letter store write request.
module tiwl_ingest (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic func,
   input  logic [tiwl_pkg::CODE_W-1:0] letter,
   input  logic last,
   input  logic [tiwl_pkg::TOTAL_W-1:0] word_total,
   output tiwl_pkg::ingest_type ing,
   output tiwl_pkg::letters_type letters
);
   import tiwl_pkg::*;

   logic [LEN_W-1:0] plen_ff, plen_in, eff, newlen;
   logic pfunc_ff;
   letters_type letters_ff;

   always_comb begin
      eff = (plen_ff != '0 && func != pfunc_ff) ? '0 : plen_ff;
      newlen = (eff <= LEN_W'(MAX_LETTERS)) ? eff + 1'b1 : eff;
      plen_in = last ? '0 : newlen;
      ing.done = accept && last;
      ing.func = func;
      ing.len = newlen;
      ing.we = accept && !func && eff < LEN_W'(MAX_LETTERS)
         && word_total < TOTAL_W'(WORD_SLOTS);
      ing.waddr = {word_total[SLOT_W-1:0], eff[IDX_W-1:0]};
      ing.wdata = letter;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         pfunc_ff <= 1'b0;
      end else if (accept) begin
         plen_ff <= plen_in;
         pfunc_ff <= func;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && eff < LEN_W'(MAX_LETTERS)) begin
         letters_ff[eff[IDX_W-1:0]] <= letter;
      end
   end

   assign letters = letters_ff;
endmodule

// ----- sv/trigram_indexed_word_lookup.sv -----
// Top level: sorted dictionary with a three-letter group index, one letter per request.
//  channel | direction | ports
//  req     | in        | req_valid req_stall req_func req_letter req_last
//  rsp     | out       | rsp_valid rsp_stall rsp_status rsp_words_stored
// A letter without last is taken in the idle state. A last letter is checked first, then compared
// letter by letter against stored words, slot by slot, through the registered letter store read.
// Queries scan their group slot by slot, so the time grows with group size.
// After reset a clearing pass over the group count memory runs, stalled.
// A result waiting in the output register does not stall letter intake.
module trigram_indexed_word_lookup (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_func,
   input  logic [4:0] req_letter,
   input  logic req_last,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [12:0] rsp_words_stored
);
   import tiwl_pkg::*;
`include "trigram_indexed_word_lookup_macros.svh"

   state_type state_ff, state_in;
   ingest_type ing;
   letters_type letters;

   logic [TOTAL_W-1:0] wt_ff, wt_in, gcnt_ff, gcnt_in, cnt_ff, cnt_in, k_ff, k_in;
   logic [TOTAL_W-1:0] slot_ff, slot_in, slot_calc;
   logic [GROUP_W-1:0] prev_ff, prev_in, clr_ff, g;
   logic [SLOT_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0] len_ff, i_ff, i_in;
   logic func_ff;
   logic [2:0] st_ff, st_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0] rsp_words_ff, rsp_words_in;

   logic [CODE_W-1:0] letter_mem [WORD_SLOTS*MAX_LETTERS];
   logic [LEN_W-1:0] wl_mem [WORD_SLOTS];
   logic [SLOT_W-1:0] gs_mem [GROUPS];
   logic [TOTAL_W-1:0] gc_mem [GROUPS];
   logic [CODE_W-1:0] w_rd_ff;
   logic [LEN_W-1:0] wl_rd_ff;
   logic [SLOT_W-1:0] gs_rd_ff;
   logic [TOTAL_W-1:0] gc_rd_ff;
   logic gs_we, gc_we, wl_we;
   logic [TOTAL_W-1:0] gc_wdata;
   logic [GROUP_W-1:0] gc_addr;

   logic accept, out_free, bad, fail_len, in_both, same;
   logic [CODE_W-1:0] cur;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   tiwl_ingest u_ingest (
      .clock(clock), .reset(reset), .accept(accept), .func(req_func),
      .letter(req_letter), .last(req_last), .word_total(wt_ff),
      .ing(ing), .letters(letters)
   );

   always_comb begin
      g = GROUP_W'(int'(letters[0]) * ALPHABET * ALPHABET
         + int'(letters[1]) * ALPHABET + int'(letters[2]));
      bad = letters[0] >= CODE_W'(ALPHABET) || letters[1] >= CODE_W'(ALPHABET)
         || letters[2] >= CODE_W'(ALPHABET);
      fail_len = len_ff < LEN_W'(GROUP_LETTERS) || len_ff > LEN_W'(MAX_LETTERS);
      slot_calc = TOTAL_W'(start_ff) + k_ff;
      cur = letters[i_ff[IDX_W-1:0]];
      in_both = i_ff < wl_rd_ff && i_ff < len_ff;
      same = in_both && w_rd_ff == cur;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == GROUP_W'(GROUPS - 1)) state_in = S_IDLE;
         S_IDLE: if (ing.done) state_in = S_CHECK;
         S_CHECK: begin
            if (func_ff) begin
               state_in = (fail_len || bad) ? S_DONE : S_GRPW;
            end else if (fail_len || wt_ff >= TOTAL_W'(WORD_SLOTS) || bad) begin
               state_in = S_DONE;
            end else if (wt_ff != '0 && g < prev_ff) begin
               state_in = S_DONE;
            end else if (wt_ff != '0 && g == prev_ff) begin
               state_in = S_CMP;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_GRPW: state_in = S_NEXT;
         S_NEXT: state_in = (k_ff >= cnt_ff || slot_calc >= wt_ff) ? S_DONE : S_CMP;
         S_CMP: begin
            if (same) begin
               state_in = S_CMP;
            end else if (func_ff) begin
               if (i_ff == len_ff || (i_ff < wl_rd_ff && cur < w_rd_ff)) state_in = S_DONE;
               else state_in = S_NEXT;
            end else if (in_both) begin
               state_in = (cur < w_rd_ff) ? S_DONE : S_COMMIT;
            end else begin
               state_in = (len_ff < wl_rd_ff) ? S_DONE : S_COMMIT;
            end
         end
         S_COMMIT: state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      wt_in = wt_ff;
      prev_in = prev_ff;
      gcnt_in = gcnt_ff;
      cnt_in = cnt_ff;
      k_in = k_ff;
      slot_in = slot_ff;
      start_in = start_ff;
      i_in = i_ff;
      st_in = st_ff;
      gs_we = 1'b0;
      gc_we = 1'b0;
      wl_we = 1'b0;
      gc_wdata = '0;
      gc_addr = g;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_words_in = rsp_words_ff;
      case (state_ff)
         S_CLEAR: begin
            gc_we = 1'b1;
            gc_addr = clr_ff;
         end
         S_CHECK: begin
            i_in = LEN_W'(GROUP_LETTERS);
            slot_in = wt_ff - 1'b1;
            if (func_ff) begin
               st_in = ST_NOT_FOUND;
            end else if (len_ff < LEN_W'(GROUP_LETTERS)) begin
               st_in = ST_SHORT;
            end else if (len_ff > LEN_W'(MAX_LETTERS)) begin
               st_in = ST_LONG;
            end else if (wt_ff >= TOTAL_W'(WORD_SLOTS)) begin
               st_in = ST_FULL;
            end else begin
               st_in = ST_ORDER;
            end
         end
         S_GRPW: begin
            start_in = gs_rd_ff;
            cnt_in = gc_rd_ff;
            k_in = '0;
         end
         S_NEXT: begin
            slot_in = slot_calc;
            i_in = LEN_W'(GROUP_LETTERS);
         end
         S_CMP: begin
            if (same) begin
               i_in = i_ff + 1'b1;
            end else if (func_ff) begin
               if (i_ff == len_ff) st_in = (i_ff == wl_rd_ff) ? ST_EXACT : ST_PREFIX;
               else k_in = k_ff + 1'b1;
            end
         end
         S_COMMIT: begin
            gc_we = 1'b1;
            wl_we = 1'b1;
            if (wt_ff == '0 || g != prev_ff) begin
               gs_we = 1'b1;
               gc_wdata = TOTAL_W'(1);
            end else begin
               gc_wdata = gcnt_ff + 1'b1;
            end
            gcnt_in = gc_wdata;
            prev_in = g;
            wt_in = wt_ff + 1'b1;
            st_in = ST_STORED;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = st_ff;
               rsp_words_in = wt_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         wt_ff <= '0;
         prev_ff <= '0;
         gcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_ff + 1'b1;
         wt_ff <= wt_in;
         prev_ff <= prev_in;
         gcnt_ff <= gcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      k_ff <= k_in;
      slot_ff <= slot_in;
      start_ff <= start_in;
      i_ff <= i_in;
      st_ff <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_words_ff <= rsp_words_in;
      if (ing.done) begin
         len_ff <= ing.len;
         func_ff <= ing.func;
      end
   end

   always_ff @(posedge clock) begin
      if (ing.we) letter_mem[ing.waddr] <= ing.wdata;
      w_rd_ff <= letter_mem[{slot_in[SLOT_W-1:0], i_in[IDX_W-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (wl_we) wl_mem[wt_ff[SLOT_W-1:0]] <= len_ff;
      wl_rd_ff <= wl_mem[slot_in[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (gs_we) gs_mem[g] <= wt_ff[SLOT_W-1:0];
      gs_rd_ff <= gs_mem[g];
   end

   always_ff @(posedge clock) begin
      if (gc_we) gc_mem[gc_addr] <= gc_wdata;
      gc_rd_ff <= gc_mem[g];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_words_stored = rsp_words_ff;

   `TIWL_ASSERT_SAME(a_stall_busy, clock, reset, state_ff != S_IDLE, req_stall)
   `TIWL_ASSERT_NEXT(a_commit_count, clock, reset, state_ff == S_COMMIT, wt_ff == $past(wt_ff) + 1'b1)
   `TIWL_ASSERT_NEXT(a_done_emits, clock, reset, state_ff == S_DONE && out_free, rsp_valid)
endmodule
